// ===== sv/sle_pkg.sv =====
// Shared types, constants and helpers for the sequential list engine.
package sle_pkg;

  localparam int DEPTH = 256;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = 32;
  localparam int CW    = 9;
  localparam logic [CW-1:0] MAX_CAP = (DEPTH < 256) ? CW'(DEPTH) : CW'(256);

  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_READ   = 3'd2,
    REQ_WRITE  = 3'd3,
    REQ_LOCATE = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL_EMP = 2'd1,
    ST_BAD_IDX  = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_FINAL,
    S_RDWAIT,
    S_SCAN
  } state_e;

  // one finished request, handed from the sequencer to the output stage
  typedef struct packed {
    logic            done;
    status_e         status;
    logic [DW-1:0]   rd;
    logic [7:0]      fpos;
    logic [CW-1:0]   count;
  } sle_res_t;

  // capacity saturated into 1 .. MAX_CAP
  function automatic logic [CW-1:0] sle_eff_cap(input logic [CW-1:0] c);
    logic [CW-1:0] r;
    r = c;
    if (r == '0) r = CW'(1);
    if (r > MAX_CAP) r = MAX_CAP;
    return r;
  endfunction

endpackage

// ===== sv/sle_ram.sv =====
// Single-port-write, single-port-read RAM with registered read data.
module sle_ram #(
  parameter int DW    = 32,
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sle_ctrl.sv =====
// Request sequencer: entry count, move/scan pointer and the entry RAM.
module sle_ctrl
  import sle_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [2:0]      req_type_i,
  input  logic [7:0]      position_i,
  input  logic [DW-1:0]   value_i,
  input  logic [CW-1:0]   cap_i,
  input  logic            cfg_we_i,
  input  logic [CW-1:0]   cfg_cap_i,
  output logic            busy_o,
  output logic [CW-1:0]   count_o,
  output sle_res_t        res_o
);

  state_e         state_q, state_d;
  req_e           op_q, op_d;
  logic [CW-1:0]  dst_q, dst_d;
  logic [CW-1:0]  pos_q, pos_d;
  logic [CW-1:0]  count_q, count_d;
  logic [DW-1:0]  val_q, val_d;

  logic           we;
  logic [CW-1:0]  waddr9, raddr9, pos9;
  logic [DW-1:0]  wdata, rdata;
  sle_res_t       res;

  sle_ram #(.DW(DW), .DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AW'(waddr9)),
    .wdata_i (wdata),
    .raddr_i (AW'(raddr9)),
    .rdata_o (rdata)
  );

  assign pos9 = {1'b0, position_i};

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    dst_d   = dst_q;
    pos_d   = pos_q;
    count_d = count_q;
    val_d   = val_q;
    we      = 1'b0;
    waddr9  = dst_q;
    wdata   = val_q;
    raddr9  = dst_q;
    res     = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d  = req_e'(req_type_i);
          val_d = value_i;
          pos_d = pos9;
          case (req_type_i)
            REQ_INSERT: begin
              if (count_q >= cap_i) begin
                res.done = 1'b1; res.status = ST_FULL_EMP;
              end else if (pos9 > count_q) begin
                res.done = 1'b1; res.status = ST_BAD_IDX;
              end else if (pos9 == count_q) begin
                // append: nothing to move
                we       = 1'b1;
                waddr9   = pos9;
                wdata    = value_i;
                count_d  = count_q + CW'(1);
                res.done = 1'b1;
              end else begin
                raddr9  = count_q - CW'(1);
                dst_d   = count_q;
                state_d = S_SHIFT;
              end
            end
            REQ_DELETE: begin
              if (count_q == '0) begin
                res.done = 1'b1; res.status = ST_FULL_EMP;
              end else if (pos9 >= count_q) begin
                res.done = 1'b1; res.status = ST_BAD_IDX;
              end else if (pos9 + CW'(1) == count_q) begin
                // last entry: drop it
                count_d  = count_q - CW'(1);
                res.done = 1'b1;
              end else begin
                raddr9  = pos9 + CW'(1);
                dst_d   = pos9;
                state_d = S_SHIFT;
              end
            end
            REQ_READ: begin
              if (count_q == '0) begin
                res.done = 1'b1; res.status = ST_FULL_EMP;
              end else if (pos9 >= count_q) begin
                res.done = 1'b1; res.status = ST_BAD_IDX;
              end else begin
                raddr9  = pos9;
                state_d = S_RDWAIT;
              end
            end
            REQ_WRITE: begin
              if (count_q == '0) begin
                res.done = 1'b1; res.status = ST_FULL_EMP;
              end else if (pos9 >= count_q) begin
                res.done = 1'b1; res.status = ST_BAD_IDX;
              end else begin
                we       = 1'b1;
                waddr9   = pos9;
                wdata    = value_i;
                res.done = 1'b1;
              end
            end
            REQ_LOCATE: begin
              if (count_q == '0) begin
                res.done = 1'b1; res.status = ST_NOTFOUND;
              end else begin
                raddr9  = '0;
                dst_d   = '0;
                state_d = S_SCAN;
              end
            end
            REQ_CLEAR: begin
              count_d  = '0;
              res.done = 1'b1;
            end
            default: begin
              res.done = 1'b1;
            end
          endcase
        end
      end
      S_SHIFT: begin
        // move the entry read last cycle into its new slot
        we     = 1'b1;
        waddr9 = dst_q;
        wdata  = rdata;
        if (op_q == REQ_INSERT) begin
          if (dst_q == pos_q + CW'(1)) begin
            state_d = S_FINAL;
          end else begin
            dst_d  = dst_q - CW'(1);
            raddr9 = dst_q - CW'(2);
          end
        end else begin
          if (dst_q + CW'(2) == count_q) begin
            count_d  = count_q - CW'(1);
            res.done = 1'b1;
            state_d  = S_IDLE;
          end else begin
            dst_d  = dst_q + CW'(1);
            raddr9 = dst_q + CW'(2);
          end
        end
      end
      S_FINAL: begin
        we       = 1'b1;
        waddr9   = pos_q;
        wdata    = val_q;
        count_d  = count_q + CW'(1);
        res.done = 1'b1;
        state_d  = S_IDLE;
      end
      S_RDWAIT: begin
        res.done = 1'b1;
        res.rd   = rdata;
        state_d  = S_IDLE;
      end
      S_SCAN: begin
        if (rdata == val_q) begin
          res.done = 1'b1;
          res.fpos = dst_q[7:0];
          state_d  = S_IDLE;
        end else if (dst_q + CW'(1) == count_q) begin
          res.done   = 1'b1;
          res.status = ST_NOTFOUND;
          state_d    = S_IDLE;
        end else begin
          dst_d  = dst_q + CW'(1);
          raddr9 = dst_q + CW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // lowered capacity drops entries above it
    if (cfg_we_i && (count_q > cfg_cap_i)) begin
      count_d = cfg_cap_i;
    end

    res.count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    dst_q <= dst_d;
    pos_q <= pos_d;
    val_q <= val_d;
  end

  assign busy_o  = (state_q != S_IDLE);
  assign count_o = count_q;
  assign res_o   = res;

endmodule

// ===== sv/sequential_list_engine.sv =====
// Top level: capacity register, request sequencer and registered result stage.
// Requests are handled one at a time; a new request is taken once the previous
//   result has been handed on. The entry RAM (one read, one write port) moves or
//   compares one entry per cycle.
// Reset: entry count 0, capacity 256; entry contents stay undefined, no clear pass.
module sequential_list_engine
  import sle_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         req_type_i,
  input  logic [7:0]         position_i,
  input  logic signed [31:0] value_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] read_value_o,
  output logic [7:0]         found_position_o,
  output logic [8:0]         entry_count_o,
  output logic               is_full_o,
  output logic               is_empty_o,
  // capacity write
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [8:0]         cfg_data_i
);

  logic [CW-1:0] cap_q;
  logic [CW-1:0] cap_eff, cfg_cap;
  logic          cfg_we;
  logic          busy, start;
  logic [CW-1:0] count;
  sle_res_t      res;

  logic          out_valid_q;
  logic [1:0]    status_q;
  logic [DW-1:0] rd_q;
  logic [7:0]    fpos_q;
  logic [CW-1:0] count_q;
  logic          full_q, empty_q;

  // capacity is held raw and saturated on use
  assign cap_eff     = sle_eff_cap(cap_q);
  assign cfg_cap     = sle_eff_cap(cfg_data_i);
  assign cfg_ready_o = !busy;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CW'(256);
    end else if (cfg_we) begin
      cap_q <= cfg_data_i;
    end
  end

  // a new request only once the sequencer is idle and the result slot is empty;
  // an offered capacity write goes first
  assign in_stall_o = busy || out_valid_q || cfg_valid_i;
  assign start      = in_valid_i && !in_stall_o;

  sle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_type_i (req_type_i),
    .position_i (position_i),
    .value_i    (value_i),
    .cap_i      (cap_eff),
    .cfg_we_i   (cfg_we),
    .cfg_cap_i  (cfg_cap),
    .busy_o     (busy),
    .count_o    (count),
    .res_o      (res)
  );

  // result register: loads when the sequencer finishes a request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.done) begin
      status_q <= res.status;
      rd_q     <= res.rd;
      fpos_q   <= res.fpos;
      count_q  <= res.count;
      full_q   <= (res.count == cap_eff);
      empty_q  <= (res.count == '0);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign read_value_o     = rd_q;
  assign found_position_o = fpos_q;
  assign entry_count_o    = count_q;
  assign is_full_o        = full_q;
  assign is_empty_o       = empty_q;

  // an accepted request always stalls the input in the cycle after it is taken
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> in_stall_o)
    else $error("request taken while previous one still in flight");

  // the list never holds more than the effective capacity
  a_count_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= cap_eff)
    else $error("entry count above capacity");

  // a finished request only while the result slot is free
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.done |-> !out_valid_q)
    else $error("result overwritten before hand-off");

  // full and empty are exclusive since capacity is at least one
  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_full_o && is_empty_o))
    else $error("list reported both full and empty");

endmodule

// ===== bench/tb_sequential_list_engine.sv =====
// Self-checking bench for the sequential list engine: random and directed requests.
module tb_sequential_list_engine;
  import sle_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Request codes six and seven are unused; the block must answer ok and change nothing.
  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;

  // Long receiver hold-off: length and the request counts at which it starts.
  localparam int HOLD_LEN   = 200;
  localparam int HOLD_FIRST = 300;
  localparam int HOLD_NEXT  = 1100;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  pos;
    logic [31:0] val;
  } list_req_t;

  typedef struct {
    status_e     status;
    logic [31:0] rd;
    logic [7:0]  fpos;
    logic [8:0]  count;
    logic        full;
    logic        empty;
  } list_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         req_type_i = '0;
  logic [7:0]         position_i = '0;
  logic signed [31:0] value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic signed [31:0] read_value_o;
  logic [7:0]         found_position_o;
  logic [8:0]         entry_count_o;
  logic               is_full_o;
  logic               is_empty_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [8:0]         cfg_data_i = '0;

  sequential_list_engine dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .read_value_o     (read_value_o),
    .found_position_o (found_position_o),
    .entry_count_o    (entry_count_o),
    .is_full_o        (is_full_o),
    .is_empty_o       (is_empty_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  // 8 ns clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run (every request a full-depth shift,
  // every result waiting out the stalls).
  initial begin
    #(25_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  list_req_t    pending_reqs[$];   // requests waiting for the driver
  list_result_t owed_results[$];   // predicted results, oldest first
  int           pushed_n = 0;      // requests handed to the driver
  int           accepted_n = 0;    // requests taken by the block
  int           cfg_done_n = 0;    // capacity writes taken by the block
  int           fail_n = 0;
  int           send_idle_pct = 14;
  int           recv_stall_pct = 88;
  logic         req_taken = 1'b0;  // request accepted at the last rising edge

  // Predictor state: its own copy of the list, the count and the capacity register.
  logic [31:0]  slots[DEPTH];
  int           live_n = 0;
  logic [8:0]   cap_reg = 9'd256;

  // Generation bookkeeping: count and limit as they will stand after the queued requests.
  int           plan_cnt = 0;
  int           plan_cap = 256;

  // Written capacity saturated into 1 .. min(DEPTH, 256); zero behaves as one.
  function automatic int cap_limit(logic [8:0] c);
    int top;
    top = (DEPTH < 256) ? DEPTH : 256;
    if (c == 9'd0) return 1;
    if (int'(c) > top) return top;
    return int'(c);
  endfunction

  // Apply one request to the predicted list and return the result it owes.
  function automatic list_result_t list_apply(list_req_t rq);
    list_result_t r;
    int           lim;
    r.status = ST_OK;
    r.rd     = '0;
    r.fpos   = '0;
    lim      = cap_limit(cap_reg);
    case (rq.op)
      REQ_INSERT: begin
        // full takes precedence over a bad index
        if (live_n >= lim) r.status = ST_FULL_EMP;
        else if (int'(rq.pos) > live_n) r.status = ST_BAD_IDX;
        else begin
          for (int i = live_n; i > int'(rq.pos); i--) slots[i] = slots[i-1];
          slots[rq.pos] = rq.val;
          live_n++;
        end
      end
      REQ_DELETE: begin
        if (live_n == 0) r.status = ST_FULL_EMP;
        else if (int'(rq.pos) >= live_n) r.status = ST_BAD_IDX;
        else begin
          for (int i = int'(rq.pos); i + 1 < live_n; i++) slots[i] = slots[i+1];
          live_n--;
        end
      end
      REQ_READ: begin
        if (live_n == 0) r.status = ST_FULL_EMP;
        else if (int'(rq.pos) >= live_n) r.status = ST_BAD_IDX;
        else r.rd = slots[rq.pos];
      end
      REQ_WRITE: begin
        if (live_n == 0) r.status = ST_FULL_EMP;
        else if (int'(rq.pos) >= live_n) r.status = ST_BAD_IDX;
        else slots[rq.pos] = rq.val;
      end
      REQ_LOCATE: begin
        // lowest matching index wins; an empty list is simply not found
        r.status = ST_NOTFOUND;
        for (int i = 0; i < live_n; i++) begin
          if (r.status == ST_NOTFOUND && slots[i] == rq.val) begin
            r.status = ST_OK;
            r.fpos   = i[7:0];
          end
        end
      end
      REQ_CLEAR: live_n = 0;
      default: ;
    endcase
    r.count = live_n[8:0];
    r.full  = (live_n == lim);
    r.empty = (live_n == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    fail_n++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents the next request at the falling edge once the previous one
  // has gone. Idle choices never look at the stall, and a stalled request holds.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    list_req_t rq;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        rq = pending_reqs.pop_front();
        req_type_i <= rq.op;
        position_i <= rq.pos;
        value_i    <= rq.val;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result-side stall: random at the current rate, plus the occasional long
  // hold-off while the driver keeps offering, so the block backs up to its input.
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  int hold_n = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (hold_n < 2 && accepted_n >= HOLD_FIRST + hold_n * HOLD_NEXT) begin
      out_stall_i <= 1'b1;
      hold_left = HOLD_LEN - 1;
      hold_n++;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge checks a delivered result against the oldest
  // prediction, then predicts for a request taken at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    list_result_t want;
    list_req_t    rq;
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result with no request pending", 32'(status_o), '0);
        end else begin
          want = owed_results.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", 32'(status_o), 32'(want.status));
          if (read_value_o !== want.rd)
            report_mismatch("read_value", read_value_o, want.rd);
          if (found_position_o !== want.fpos)
            report_mismatch("found_position", 32'(found_position_o), 32'(want.fpos));
          if (entry_count_o !== want.count)
            report_mismatch("entry_count", 32'(entry_count_o), 32'(want.count));
          if (is_full_o !== want.full)
            report_mismatch("is_full", 32'(is_full_o), 32'(want.full));
          if (is_empty_o !== want.empty)
            report_mismatch("is_empty", 32'(is_empty_o), 32'(want.empty));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        rq.op  = req_type_i;
        rq.pos = position_i;
        rq.val = value_i;
        owed_results.push_back(list_apply(rq));
        accepted_n++;
      end
      // a capacity below the count drops the entries above it
      if (cfg_valid_i && cfg_ready_o) begin
        cap_reg = cfg_data_i;
        if (live_n > cap_limit(cap_reg)) live_n = cap_limit(cap_reg);
        cfg_done_n++;
      end
      req_taken <= in_valid_i && !in_stall_o;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_req(logic [2:0] op, logic [7:0] pos, logic [31:0] val);
    list_req_t rq;
    rq.op  = op;
    rq.pos = pos;
    rq.val = val;
    // track only the count, so that later positions can be chosen in range
    if (op == REQ_INSERT && plan_cnt < plan_cap && int'(pos) <= plan_cnt) plan_cnt++;
    if (op == REQ_DELETE && plan_cnt > 0 && int'(pos) < plan_cnt) plan_cnt--;
    if (op == REQ_CLEAR) plan_cnt = 0;
    pending_reqs.push_back(rq);
    pushed_n++;
  endtask

  // Every request taken and answered, then a short pause.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (accepted_n != pushed_n || owed_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Capacity is only written with the block idle.
  task automatic set_capacity(logic [8:0] c);
    int target;
    target = cfg_done_n + 1;
    cfg_data_i  <= c;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i);
    while (cfg_done_n != target);
    cfg_valid_i <= 1'b0;
    plan_cap = cap_limit(c);
    if (plan_cnt > plan_cap) plan_cnt = plan_cap;
  endtask

  // Half the values come from a small pool so that locate hits, often on duplicates.
  function automatic logic [31:0] pick_value();
    logic [31:0] pool[8];
    pool = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'd42};
    if ($urandom_range(0, 1) == 0) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // Mostly well-formed requests at positions in range; grow_pct steers the list size.
  task automatic random_burst(int n, int grow_pct);
    int k;
    int top;
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(0, 99) < 8) begin
        // noise: any code, any position
        push_req(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), $urandom);
      end else if (plan_cnt == 0 || $urandom_range(0, 99) < grow_pct) begin
        top = (plan_cnt > 255) ? 255 : plan_cnt;
        push_req(REQ_INSERT, 8'($urandom_range(0, top)), pick_value());
      end else begin
        k = $urandom_range(0, 19);
        if (k == 0 && grow_pct < 60) push_req(REQ_CLEAR, 8'($urandom), $urandom);
        else if (k <= 5) push_req(REQ_DELETE, 8'($urandom_range(0, plan_cnt - 1)), $urandom);
        else if (k <= 10) push_req(REQ_READ, 8'($urandom_range(0, plan_cnt - 1)), $urandom);
        else if (k <= 14)
          push_req(REQ_WRITE, 8'($urandom_range(0, plan_cnt - 1)), pick_value());
        else push_req(REQ_LOCATE, 8'($urandom), pick_value());
      end
    end
  endtask

  initial begin
    // reset asserted from time zero, released on a falling edge
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty-list errors, unused codes, extreme values, bad indices,
    // duplicate values for locate, deleting the last entry, clear.
    push_req(REQ_DELETE, 8'd0, 32'h0);
    push_req(REQ_READ, 8'd0, 32'h0);
    push_req(REQ_WRITE, 8'd0, 32'h1);
    push_req(REQ_LOCATE, 8'd0, 32'h0);
    push_req(REQ_INSERT, 8'd1, 32'h3);
    push_req(REQ_SPARE_A, 8'd0, 32'h0);
    push_req(REQ_SPARE_B, 8'hFF, 32'hFFFF_FFFF);
    push_req(REQ_INSERT, 8'd0, 32'h8000_0000);
    push_req(REQ_INSERT, 8'd1, 32'h7FFF_FFFF);
    push_req(REQ_INSERT, 8'd0, 32'h0);
    push_req(REQ_INSERT, 8'd4, 32'h9);
    push_req(REQ_INSERT, 8'd2, 32'hFFFF_FFFF);
    push_req(REQ_READ, 8'd3, 32'h0);
    push_req(REQ_READ, 8'd0, 32'h0);
    push_req(REQ_READ, 8'd4, 32'h0);
    push_req(REQ_READ, 8'hFF, 32'h0);
    push_req(REQ_WRITE, 8'd0, 32'h7FFF_FFFF);
    push_req(REQ_LOCATE, 8'd0, 32'h7FFF_FFFF);
    push_req(REQ_LOCATE, 8'd0, 32'd12345);
    push_req(REQ_DELETE, 8'hFF, 32'h0);
    push_req(REQ_WRITE, 8'd4, 32'h0);
    push_req(REQ_DELETE, 8'd0, 32'h0);
    push_req(REQ_DELETE, 8'd2, 32'h0);
    push_req(REQ_LOCATE, 8'd0, 32'hFFFF_FFFF);
    push_req(REQ_CLEAR, 8'd0, 32'h0);
    wait_drained();

    // a written zero behaves as one: full is reported before a bad index
    set_capacity(9'd0);
    push_req(REQ_INSERT, 8'd0, 32'h1234_5678);
    push_req(REQ_INSERT, 8'd5, 32'h0);
    push_req(REQ_DELETE, 8'd1, 32'h0);
    push_req(REQ_READ, 8'd0, 32'h0);
    random_burst(120, 50);
    wait_drained();

    set_capacity(9'd3);
    random_burst(250, 55);
    wait_drained();

    // sender now idles more than the receiver; capacity above 256 saturates,
    // and the list is driven up to a full 256 entries
    send_idle_pct  = 88;
    recv_stall_pct = 14;
    set_capacity(9'd511);
    random_burst(500, 90);
    wait_drained();

    // lowering the capacity below the count cuts the list
    set_capacity(9'd5);
    random_burst(250, 50);
    wait_drained();

    // no random idling on either side (the second long receiver hold-off still falls here)
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_capacity(9'd256);
    random_burst(300, 65);
    wait_drained();

    set_capacity(9'd40);
    random_burst(300, 60);
    wait_drained();

    set_capacity(9'd200);
    random_burst(250, 55);
    wait_drained();

    // let any stray result show up before the verdict
    repeat (300) @(negedge clk_i);
    if (owed_results.size() != 0)
      report_mismatch("results never delivered", 32'(owed_results.size()), '0);

    if (fail_n == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sequential_list_engine.f =====
sv/sle_pkg.sv
sv/sle_ram.sv
sv/sle_ctrl.sv
sv/sequential_list_engine.sv
bench/tb_sequential_list_engine.sv
